// File: rtl/rbst_pkg.sv
// ============================================================================
// rbst_pkg
// Shared widths, types and limits for the 2D ray versus box slab test.
// ============================================================================
package rbst_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int COORD_WIDTH = 32;

    localparam int W  = COORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int QB = W + 1;
    localparam int NL = 4;
    localparam int NS = QB + 5;

    localparam int SF = QB + 1;
    localparam int SO = QB + 2;
    localparam int SN = QB + 3;
    localparam int SQ = QB + 4;

    typedef logic signed [W-1:0] coord_t;
    typedef logic        [W-2:0] dim_t;

    localparam coord_t T_MAX = {1'b0, {(W-1){1'b1}}};
    localparam coord_t T_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [QB-1:0] Q_HALF = {{(QB-W){1'b0}}, T_MIN};

endpackage

// File: rtl/rbst_if.sv
// ============================================================================
// rbst_req_if / rbst_rsp_if
// Valid/ready channels for ray and box requests and for test results.
// ============================================================================
interface rbst_req_if;
    import rbst_pkg::*;

    logic   valid;
    logic   ready;
    coord_t origin_x;
    coord_t origin_y;
    coord_t dir_x;
    coord_t dir_y;
    coord_t box_x;
    coord_t box_y;
    dim_t   box_w;
    dim_t   box_h;

    modport source
    (
        output valid, origin_x, origin_y, dir_x, dir_y, box_x, box_y, box_w, box_h,
        input  ready
    );
    modport sink
    (
        input  valid, origin_x, origin_y, dir_x, dir_y, box_x, box_y, box_w, box_h,
        output ready
    );
endinterface

interface rbst_rsp_if;
    import rbst_pkg::*;

    logic   valid;
    logic   ready;
    logic   hit;
    coord_t entry_dist;

    modport source
    (
        output valid, hit, entry_dist,
        input  ready
    );
    modport sink
    (
        input  valid, hit, entry_dist,
        output ready
    );
endinterface

// File: rtl/ray_box_slab_test_2d.sv
// ============================================================================
// ray_box_slab_test_2d
// Slab test of a 2D ray line against an axis-aligned box in signed fixed
// point; reports hit and saturated entry parameter.
// ============================================================================
// Pipeline from request transaction to result (Q16.16 coordinates): one prep
// stage, one stage per quotient bit of the four restoring dividers, then fixup,
// ordering, narrowing and output stages.
// Throughput: one transaction per cycle while the result side is ready; bubbles collapse under a stall.
// Reset clears the stage valid bits only.
module ray_box_slab_test_2d
(
    input  logic            clk,
    input  logic            rst_n,
    rbst_req_if.sink        req,
    rbst_rsp_if.source      rsp
);
    import rbst_pkg::*;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] en;

    // prep stage
    logic [W:0]    p_num_reg [NL];
    logic [W-1:0]  p_den_reg [NL];
    logic [NL-1:0] p_neg_reg;
    logic [1:0]    p_par_reg;
    logic [1:0]    p_ins_reg;
    logic [W:0]    p_num_next [NL];
    logic [W-1:0]  p_den_next [NL];
    logic [NL-1:0] p_neg_next;
    logic [1:0]    p_par_next;
    logic [1:0]    p_ins_next;

    // divider stages
    logic [W-1:0]  dv_rem_reg [QB][NL];
    logic [QB-1:0] dv_low_reg [QB][NL];
    logic [QB-1:0] dv_quo_reg [QB][NL];
    logic [W-1:0]  dv_den_reg [QB][NL];
    logic [NL-1:0] dv_neg_reg [QB];
    logic [NL-1:0] dv_sat_reg [QB];
    logic [1:0]    dv_par_reg [QB];
    logic [1:0]    dv_ins_reg [QB];
    logic [W-1:0]  dv_rem_next [QB][NL];
    logic [QB-1:0] dv_low_next [QB][NL];
    logic [QB-1:0] dv_quo_next [QB][NL];
    logic [W-1:0]  dv_den_next [QB][NL];
    logic [NL-1:0] dv_neg_next [QB];
    logic [NL-1:0] dv_sat_next [QB];
    logic [1:0]    dv_par_next [QB];
    logic [1:0]    dv_ins_next [QB];

    // fixup, order, narrow, output
    coord_t        f_t_reg [NL];
    coord_t        f_t_next [NL];
    logic [1:0]    f_par_reg;
    logic [1:0]    f_ins_reg;
    coord_t        o_tmin_reg [2];
    coord_t        o_tmax_reg [2];
    coord_t        o_tmin_next [2];
    coord_t        o_tmax_next [2];
    logic [1:0]    o_par_reg;
    logic [1:0]    o_ins_reg;
    logic          n_hit_reg;
    coord_t        n_near_reg;
    coord_t        n_far_reg;
    logic          n_hit_next;
    coord_t        n_near_next;
    coord_t        n_far_next;
    logic          q_hit_reg;
    coord_t        q_dist_reg;
    logic          q_hit_next;
    coord_t        q_dist_next;

    coord_t        org [2];
    coord_t        dir [2];
    coord_t        bxs [2];
    dim_t          siz [2];

    assign org[0] = req.origin_x;
    assign org[1] = req.origin_y;
    assign dir[0] = req.dir_x;
    assign dir[1] = req.dir_y;
    assign bxs[0] = req.box_x;
    assign bxs[1] = req.box_y;
    assign siz[0] = req.box_w;
    assign siz[1] = req.box_h;

    // handshake and bubble collapse
    always_comb
    begin
        en[NS-1] = !vld_reg[NS-1] || rsp.ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign req.ready      = en[0];
    assign rsp.valid      = vld_reg[NS-1];
    assign rsp.hit        = q_hit_reg;
    assign rsp.entry_dist = q_dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= (k == 0) ? req.valid : vld_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    // prep: bounds, differences, magnitudes, parallel and inside checks
    always_comb
    begin
        logic signed [W+1:0] org_e;
        logic signed [W+1:0] lo_e;
        logic signed [W+1:0] hi_e;
        logic signed [W+1:0] d0;
        logic signed [W+1:0] d1;
        logic signed [W+1:0] m0;
        logic signed [W+1:0] m1;
        logic signed [W:0]   dir_e;
        logic signed [W:0]   dm;
        for (int a = 0; a < 2; a++)
        begin
            org_e = {{2{org[a][W-1]}}, org[a]};
            lo_e  = {{2{bxs[a][W-1]}}, bxs[a]};
            hi_e  = lo_e + $signed({3'b000, siz[a]});
            d0    = lo_e - org_e;
            d1    = hi_e - org_e;
            m0    = d0[W+1] ? -d0 : d0;
            m1    = d1[W+1] ? -d1 : d1;
            dir_e = {dir[a][W-1], dir[a]};
            dm    = dir[a][W-1] ? -dir_e : dir_e;
            p_num_next[2*a]   = m0[W:0];
            p_num_next[2*a+1] = m1[W:0];
            p_den_next[2*a]   = dm[W-1:0];
            p_den_next[2*a+1] = dm[W-1:0];
            p_neg_next[2*a]   = d0[W+1] ^ dir[a][W-1];
            p_neg_next[2*a+1] = d1[W+1] ^ dir[a][W-1];
            p_par_next[a]     = (dir[a] == '0);
            p_ins_next[a]     = (org_e >= lo_e) && (org_e <= hi_e);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p_num_reg <= p_num_next;
            p_den_reg <= p_den_next;
            p_neg_reg <= p_neg_next;
            p_par_reg <= p_par_next;
            p_ins_reg <= p_ins_next;
        end
    end

    // restoring division, one quotient bit per stage
    always_comb
    begin
        logic [W-1:0]  r;
        logic [QB-1:0] low;
        logic [QB-1:0] quo;
        logic [W+1:0]  trial;
        logic          bitn;
        for (int k = 0; k < QB; k++)
        begin
            for (int l = 0; l < NL; l++)
            begin
                if (k == 0)
                begin
                    r   = {{(W-F){1'b0}}, p_num_reg[l][W -: F]};
                    low = {p_num_reg[l][W-F:0], {F{1'b0}}};
                    quo = '0;
                    dv_den_next[k][l] = p_den_reg[l];
                end
                else
                begin
                    r   = dv_rem_reg[(k == 0) ? 0 : k - 1][l];
                    low = dv_low_reg[(k == 0) ? 0 : k - 1][l];
                    quo = dv_quo_reg[(k == 0) ? 0 : k - 1][l];
                    dv_den_next[k][l] = dv_den_reg[(k == 0) ? 0 : k - 1][l];
                end
                bitn  = low[QB-1];
                trial = {1'b0, r, bitn} - {2'b00, dv_den_next[k][l]};
                dv_rem_next[k][l] = trial[W+1] ? {r[W-2:0], bitn} : trial[W-1:0];
                dv_low_next[k][l] = {low[QB-2:0], 1'b0};
                dv_quo_next[k][l] = {quo[QB-2:0], !trial[W+1]};
            end
            if (k == 0)
            begin
                for (int l = 0; l < NL; l++)
                begin
                    dv_sat_next[k][l] = {{(W-F){1'b0}}, p_num_reg[l], {F{1'b0}}}
                                        >= {p_den_reg[l], {QB{1'b0}}};
                end
                dv_neg_next[k] = p_neg_reg;
                dv_par_next[k] = p_par_reg;
                dv_ins_next[k] = p_ins_reg;
            end
            else
            begin
                dv_sat_next[k] = dv_sat_reg[(k == 0) ? 0 : k - 1];
                dv_neg_next[k] = dv_neg_reg[(k == 0) ? 0 : k - 1];
                dv_par_next[k] = dv_par_reg[(k == 0) ? 0 : k - 1];
                dv_ins_next[k] = dv_ins_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < QB; k++)
        begin
            if (en[k+1])
            begin
                dv_rem_reg[k] <= dv_rem_next[k];
                dv_low_reg[k] <= dv_low_next[k];
                dv_quo_reg[k] <= dv_quo_next[k];
                dv_den_reg[k] <= dv_den_next[k];
                dv_neg_reg[k] <= dv_neg_next[k];
                dv_sat_reg[k] <= dv_sat_next[k];
                dv_par_reg[k] <= dv_par_next[k];
                dv_ins_reg[k] <= dv_ins_next[k];
            end
        end
    end

    // sign and saturation fixup
    always_comb
    begin
        logic [QB-1:0] q;
        logic          sat;
        for (int l = 0; l < NL; l++)
        begin
            q   = dv_quo_reg[QB-1][l];
            sat = dv_sat_reg[QB-1][l] || (q > Q_HALF);
            if (dv_neg_reg[QB-1][l])
            begin
                f_t_next[l] = sat ? T_MIN : -$signed(q[W-1:0]);
            end
            else
            begin
                f_t_next[l] = (sat || q >= Q_HALF) ? T_MAX : $signed(q[W-1:0]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[SF])
        begin
            f_t_reg   <= f_t_next;
            f_par_reg <= dv_par_reg[QB-1];
            f_ins_reg <= dv_ins_reg[QB-1];
        end
    end

    // order entry and exit per axis
    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            if (f_t_reg[2*a] > f_t_reg[2*a+1])
            begin
                o_tmin_next[a] = f_t_reg[2*a+1];
                o_tmax_next[a] = f_t_reg[2*a];
            end
            else
            begin
                o_tmin_next[a] = f_t_reg[2*a];
                o_tmax_next[a] = f_t_reg[2*a+1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[SO])
        begin
            o_tmin_reg <= o_tmin_next;
            o_tmax_reg <= o_tmax_next;
            o_par_reg  <= f_par_reg;
            o_ins_reg  <= f_ins_reg;
        end
    end

    // narrow the interval
    always_comb
    begin
        logic   hit1;
        coord_t near1;
        coord_t far1;
        hit1  = o_par_reg[0] ? o_ins_reg[0] : 1'b1;
        near1 = o_par_reg[0] ? T_MIN : o_tmin_reg[0];
        far1  = o_par_reg[0] ? T_MAX : o_tmax_reg[0];
        if (o_par_reg[1])
        begin
            n_hit_next  = hit1 && o_ins_reg[1];
            n_near_next = near1;
            n_far_next  = far1;
        end
        else
        begin
            n_hit_next  = hit1 && !((o_tmax_reg[1] < near1) || (o_tmin_reg[1] > far1));
            n_near_next = (o_tmin_reg[1] > near1) ? o_tmin_reg[1] : near1;
            n_far_next  = (o_tmax_reg[1] < far1) ? o_tmax_reg[1] : far1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[SN])
        begin
            n_hit_reg  <= n_hit_next;
            n_near_reg <= n_near_next;
            n_far_reg  <= n_far_next;
        end
    end

    // final check and output register
    always_comb
    begin
        q_hit_next  = n_hit_reg && (n_near_reg <= n_far_reg);
        q_dist_next = q_hit_next ? n_near_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en[SQ])
        begin
            q_hit_reg  <= q_hit_next;
            q_dist_reg <= q_dist_next;
        end
    end

endmodule

// File: bench/ray_box_slab_test_2d_test.sv
// ============================================================================
// ray_box_slab_test_2d_test
// Streams rays and boxes into the slab tester with random gaps and result
// stalls, predicts hit and entry distance per transaction, and compares them.
// ============================================================================
module ray_box_slab_test_2d_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rbst_pkg::*;

    typedef struct {
        coord_t ox, oy, dx, dy, bx, by;
        dim_t   bw, bh;
    } ray_box_t;

    typedef struct {
        logic   hit;
        coord_t entry;
    } slab_hit_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    longint cycles = 0;
    int     n_fail = 0;
    int     n_mismatch = 0;
    int     n_results = 0;
    int     n_hits = 0;
    slab_hit_t pending_hits[$];

    rbst_req_if req ();
    rbst_rsp_if rsp ();

    ray_box_slab_test_2d dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    localparam longint LIM_HI = (64'sd1 <<< (W-1)) - 1;
    localparam longint LIM_LO = -(64'sd1 <<< (W-1));

    function automatic longint fx_quotient(longint num, longint den);
        logic   neg;
        longint n, d, q, r;
        logic   sat;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        q = n / d;
        r = n % d;
        sat = q > -LIM_LO;
        for (int i = 0; i < F && !sat; i++)
        begin
            r = r <<< 1;
            q = q <<< 1;
            if (r >= d)
            begin
                r = r - d;
                q = q | 1;
            end
            if (q > -LIM_LO)
                sat = 1'b1;
        end
        if (neg)
            return sat ? LIM_LO : -q;
        if (sat || q > LIM_HI)
            return LIM_HI;
        return q;
    endfunction

    function automatic logic narrow_axis(longint org, longint dir, longint lo, longint size,
                                         ref longint t_near, ref longint t_far);
        longint hi, t0, t1, s;
        hi = lo + size;
        if (dir == 0)
            return org >= lo && org <= hi;
        t0 = fx_quotient(lo - org, dir);
        t1 = fx_quotient(hi - org, dir);
        if (t0 > t1)
        begin
            s = t0;
            t0 = t1;
            t1 = s;
        end
        if (t1 < t_near || t0 > t_far)
            return 1'b0;
        if (t0 > t_near)
            t_near = t0;
        if (t1 < t_far)
            t_far = t1;
        return 1'b1;
    endfunction

    function automatic slab_hit_t predict_hit(ray_box_t rb);
        longint    t_near, t_far;
        logic      h;
        slab_hit_t res;
        t_near = LIM_LO;
        t_far = LIM_HI;
        h = narrow_axis(longint'(rb.ox), longint'(rb.dx), longint'(rb.bx),
                        longint'({1'b0, rb.bw}), t_near, t_far);
        if (h)
            h = narrow_axis(longint'(rb.oy), longint'(rb.dy), longint'(rb.by),
                            longint'({1'b0, rb.bh}), t_near, t_far);
        if (h && t_near > t_far)
            h = 1'b0;
        res.hit = h;
        res.entry = h ? coord_t'(t_near) : '0;
        return res;
    endfunction

    task automatic send_burst(ray_box_t rb);
        req.valid    <= 1'b1;
        req.origin_x <= rb.ox;
        req.origin_y <= rb.oy;
        req.dir_x    <= rb.dx;
        req.dir_y    <= rb.dy;
        req.box_x    <= rb.bx;
        req.box_y    <= rb.by;
        req.box_w    <= rb.bw;
        req.box_h    <= rb.bh;
        do @(posedge clk); while (!req.ready);
        pending_hits.push_back(predict_hit(rb));
    endtask

    task automatic send_ray(ray_box_t rb);
        int idle;
        idle = $urandom_range(0, 4);
        if (idle != 0)
        begin
            req.valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        send_burst(rb);
    endtask

    task automatic hold_idle();
        req.valid <= 1'b0;
    endtask

    function automatic coord_t pick_coord();
        case ($urandom_range(0, 5))
            0: return coord_t'($urandom);
            1: return T_MAX - coord_t'($urandom_range(0, 3));
            2: return T_MIN + coord_t'($urandom_range(0, 3));
            default: return coord_t'(int'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
        endcase
    endfunction

    function automatic dim_t pick_dim();
        case ($urandom_range(0, 4))
            0: return dim_t'($urandom);
            1: return '1;
            2: return '0;
            default: return dim_t'($urandom_range(0, 32'h0010_0000));
        endcase
    endfunction

    function automatic coord_t pick_dir();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return coord_t'($urandom);
            2: return coord_t'(int'($urandom_range(0, 8)) - 4);
            default: return coord_t'(int'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
        endcase
    endfunction

    function automatic ray_box_t aimed_ray();
        ray_box_t rb;
        rb.bx = coord_t'(int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
        rb.by = coord_t'(int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
        rb.bw = dim_t'($urandom_range(0, 32'h0008_0000));
        rb.bh = dim_t'($urandom_range(0, 32'h0008_0000));
        rb.ox = coord_t'(int'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
        rb.oy = coord_t'(int'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
        rb.dx = rb.bx + coord_t'(rb.bw >> 1) - rb.ox + coord_t'($urandom_range(0, 255));
        rb.dy = rb.by + coord_t'(rb.bh >> 1) - rb.oy + coord_t'($urandom_range(0, 255));
        return rb;
    endfunction

    function automatic ray_box_t mk(coord_t ox, coord_t oy, coord_t dx, coord_t dy,
                                    coord_t bx, coord_t by, dim_t bw, dim_t bh);
        ray_box_t rb;
        rb.ox = ox; rb.oy = oy; rb.dx = dx; rb.dy = dy;
        rb.bx = bx; rb.by = by; rb.bw = bw; rb.bh = bh;
        return rb;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rsp.valid && rsp.ready)
        begin
            n_results <= n_results + 1;
            if (pending_hits.size() == 0)
            begin
                n_fail++;
                $display("unexpected result transaction: hit=%0b dist=%0d",
                         rsp.hit, rsp.entry_dist);
            end
            else
            begin
                slab_hit_t exp_hit;
                exp_hit = pending_hits.pop_front();
                if (rsp.hit !== exp_hit.hit || rsp.entry_dist !== exp_hit.entry)
                begin
                    n_fail++;
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: expected hit=%0b dist=%0d, got hit=%0b dist=%0d",
                                 exp_hit.hit, exp_hit.entry, rsp.hit, rsp.entry_dist);
                end
                if (exp_hit.hit)
                    n_hits <= n_hits + 1;
            end
        end
    end

    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 3) == 0)
                rsp.ready <= ($urandom_range(0, 4) == 0);
            else
                rsp.ready <= 1'b1;
        end
    end

    initial
    begin
        wait (cycles > 2_000_000);
        $display("timeout after %0d cycles", cycles);
        $display("ray_box_slab_test_2d_test failed");
        $finish;
    end

    task automatic test_corners();
        send_ray(mk(0, 0, 32'sh0001_0000, 32'sh0001_0000, 32'sh0002_0000, 32'sh0002_0000,
                    31'h0001_0000, 31'h0001_0000));
        send_ray(mk(32'sh0000_8000, 32'sh0000_8000, 0, 0, 0, 0, 31'h0001_0000, 31'h0001_0000));
        send_ray(mk(32'sh0005_0000, 0, 0, 32'sh0001_0000, 0, 0, 31'h0001_0000, 31'h0001_0000));
        send_ray(mk(32'sh0001_0000, 0, 0, 32'sh0001_0000, 0, 0, 31'h0001_0000, 31'h0001_0000));
        send_ray(mk(0, 0, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 0, 0, 0));
        send_ray(mk(0, 0, 32'sh0001_0000, -32'sh0001_0000, 32'sh0003_0000, 0,
                    31'h0001_0000, 31'h0001_0000));
        send_ray(mk(T_MIN, T_MIN, 1, 1, T_MAX, T_MAX, '1, '1));
        send_ray(mk(T_MAX, T_MAX, T_MIN, T_MIN, T_MIN, T_MIN, '1, '1));
        send_ray(mk(T_MIN, T_MAX, T_MAX, T_MIN, T_MIN, T_MIN, '1, '1));
        send_ray(mk(0, 0, -1, 1, T_MIN, T_MIN, '1, '1));
        send_ray(mk(0, 0, T_MIN, T_MIN, T_MIN, T_MIN, 0, 0));
        send_ray(mk(-1, -1, T_MAX, 0, 0, -1, 0, 0));
        send_ray(mk(0, 0, 32'sh0001_0000, 32'sh0002_0000, 32'sh0004_0000, 0,
                    31'h0001_0000, 31'h0001_0000));
        send_ray(mk(32'sh0000_1234, -32'sh0000_4321, 3, -7, 32'sh0001_0000, -32'sh0001_0000,
                    31'h0000_0101, 31'h0002_0000));
        send_ray(mk(T_MAX, T_MIN, 0, 0, T_MAX, T_MIN, '0, '0));
    endtask

    task automatic test_random_mix(int count);
        ray_box_t rb;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 2) != 0)
                rb = aimed_ray();
            else
                rb = mk(pick_coord(), pick_coord(), pick_dir(), pick_dir(),
                        pick_coord(), pick_coord(), pick_dim(), pick_dim());
            send_ray(rb);
        end
    endtask

    task automatic test_drain_pause();
        hold_idle();
        wait (pending_hits.size() == 0);
        repeat (50) @(posedge clk);
    endtask

    task automatic test_back_to_back(int count);
        for (int i = 0; i < count; i++)
            send_burst(aimed_ray());
    endtask

    initial
    begin
        req.valid    = 1'b0;
        req.origin_x = '0;
        req.origin_y = '0;
        req.dir_x    = '0;
        req.dir_y    = '0;
        req.box_x    = '0;
        req.box_y    = '0;
        req.box_w    = '0;
        req.box_h    = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corners();
        test_random_mix(450);
        test_drain_pause();
        test_back_to_back(80);
        test_random_mix(400);
        hold_idle();
        wait (pending_hits.size() == 0);
        repeat (60) @(posedge clk);
        $display("covered %0d result transactions, %0d hits, across corner, aimed and random rays",
                 n_results, n_hits);
        if (n_fail == 0)
            $display("ray_box_slab_test_2d_test passed");
        else
            $display("ray_box_slab_test_2d_test failed");
        $finish;
    end
endmodule
